@@ hw/rtl/dlc_pkg.sv @@
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared constants, types and helpers of the double-layer curl near-field
// pipeline.
// ----------------------------------------------------------------------------
package dlc_pkg;

    // Fraction bits of the Q-format inputs
    localparam int FRAC_BITS = 16;

    // Widths of the square root and of the divider words
    localparam int DE_W = 31;
    localparam int DV_W = 32;

    // Stage counts of each section
    localparam int NF = 6;
    localparam int NS = DE_W;
    localparam int ND = DV_W;
    localparam int NB = 12;

    // First stage index of each section in the global valid chain
    localparam int SQ_LO = NF;
    localparam int DV_LO = SQ_LO + NS;
    localparam int BK_LO = DV_LO + ND;
    localparam int NSTG  = BK_LO + NB;

    // Divider lanes: three unit-vector lanes and one reciprocal lane
    localparam int NLANE = 4;
    localparam int RCP_LANE = 3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_COIN = 2'd2
    } t_status;

    // Per-item side information carried along the pipeline
    typedef struct packed {
        logic [2:0][31:0]   nv;     // normal n, raw signed words
        logic [2:0][31:0]   av;     // vector A, raw signed words
        logic [2:0]         neg;    // sign of each component of d
        logic signed [5:0]  k;      // normalizing exponent
        logic               zero;   // coincident points
    } t_side;

    // Bit length of an unsigned word (position of the top set bit, plus one)
    function automatic logic [6:0] bitlen64(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int b = 0; b < 64; b++) begin
            if (x[b]) begin
                n = 7'(b + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/dlc_if.sv @@
// ----------------------------------------------------------------------------
// dlc_if
// Valid/ready channels of the curl pipeline: one input word, one result word.
// ----------------------------------------------------------------------------
interface dlc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eval_x;
    logic signed [31:0] eval_y;
    logic signed [31:0] eval_z;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] moment_x;
    logic signed [31:0] moment_y;
    logic signed [31:0] moment_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;

    modport source (
        output valid, eval_x, eval_y, eval_z, src_x, src_y, src_z,
               moment_x, moment_y, moment_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, eval_x, eval_y, eval_z, src_x, src_y, src_z,
               moment_x, moment_y, moment_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

interface dlc_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] curl_x;
    logic signed [47:0] curl_y;
    logic signed [47:0] curl_z;
    logic [1:0]         status;

    modport source (
        output valid, curl_x, curl_y, curl_z, status,
        input  ready
    );
    modport sink (
        input  valid, curl_x, curl_y, curl_z, status,
        output ready
    );
endinterface

@@ hw/rtl/dlc_front.sv @@
// ----------------------------------------------------------------------------
// dlc_front
// Front stages: difference vector, block normalization to 30 bits and the
// sum of squares that feeds the square root.
// ----------------------------------------------------------------------------
module dlc_front (
    input  logic                    i_clk,
    input  logic [dlc_pkg::NF-1:0]  i_en,
    input  logic [2:0][31:0]        i_eval,
    input  logic [2:0][31:0]        i_src,
    input  logic [2:0][31:0]        i_mom,
    input  logic [2:0][31:0]        i_nrm,
    output logic [61:0]             o_sq,
    output logic [2:0][29:0]        o_em,
    output dlc_pkg::t_side          o_side
);

    logic signed [32:0] r_d [3];
    logic [32:0]        r_mag1 [3];
    logic [32:0]        r_mag2 [3];
    logic [32:0]        r_mx;
    logic [2:0][29:0]   r_em3;
    logic [2:0][29:0]   r_em4;
    logic [2:0][29:0]   r_em5;
    logic [59:0]        r_sq [3];
    logic [61:0]        r_sum;
    dlc_pkg::t_side     r_side [dlc_pkg::NF];

    logic [32:0]        w_mag [3];
    logic [32:0]        w_mx;
    logic [6:0]         w_len;
    int                 w_k;
    logic [63:0]        w_sh [3];

    // Magnitudes and their maximum
    always_comb begin
        w_mx = '0;
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = r_d[l][32] ? 33'(-r_d[l]) : 33'(r_d[l]);
            if (w_mag[l] > w_mx) begin
                w_mx = w_mag[l];
            end
        end
    end

    // Exponent from the bit length of the maximum
    always_comb begin
        w_len = dlc_pkg::bitlen64(64'(r_mx));
        w_k   = int'(w_len) - 30;
    end

    // Normalizing shift
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_side[2].k[5]) begin
                w_sh[l] = 64'(r_mag2[l]) << 6'(-r_side[2].k);
            end else begin
                w_sh[l] = 64'(r_mag2[l]) >> r_side[2].k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // take the word and form d = r - rp
        if (i_en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_d[l] <= 33'($signed(i_eval[l])) - 33'($signed(i_src[l]));
            end
            r_side[0].nv   <= i_nrm;
            r_side[0].av   <= i_mom;
            r_side[0].neg  <= '0;
            r_side[0].k    <= '0;
            r_side[0].zero <= 1'b0;
        end
        // magnitudes, signs, maximum
        if (i_en[1]) begin
            r_mag1        <= w_mag;
            r_mx          <= w_mx;
            r_side[1]     <= r_side[0];
            for (int l = 0; l < 3; l++) begin
                r_side[1].neg[l] <= r_d[l][32];
            end
        end
        // exponent and coincidence flag
        if (i_en[2]) begin
            r_mag2         <= r_mag1;
            r_side[2]      <= r_side[1];
            r_side[2].k    <= 6'(w_k);
            r_side[2].zero <= (r_mx == '0);
        end
        // normalized magnitudes
        if (i_en[3]) begin
            for (int l = 0; l < 3; l++) begin
                r_em3[l] <= w_sh[l][29:0];
            end
            r_side[3] <= r_side[2];
        end
        // squares
        if (i_en[4]) begin
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= 60'(r_em3[l]) * 60'(r_em3[l]);
            end
            r_em4     <= r_em3;
            r_side[4] <= r_side[3];
        end
        // sum of squares
        if (i_en[5]) begin
            r_sum     <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
            r_em5     <= r_em4;
            r_side[5] <= r_side[4];
        end
    end

    assign o_sq   = r_sum;
    assign o_em   = r_em5;
    assign o_side = r_side[dlc_pkg::NF-1];

endmodule

@@ hw/rtl/dlc_sqrt.sv @@
// ----------------------------------------------------------------------------
// dlc_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module dlc_sqrt (
    input  logic                         i_clk,
    input  logic [dlc_pkg::NS-1:0]       i_en,
    input  logic [61:0]                  i_sq,
    input  logic [2:0][29:0]             i_em,
    input  dlc_pkg::t_side               i_side,
    output logic [dlc_pkg::DE_W-1:0]     o_de,
    output logic [2:0][29:0]             o_em,
    output dlc_pkg::t_side               o_side
);

    logic [63:0]               r_rem  [dlc_pkg::NS];
    logic [dlc_pkg::DE_W-1:0]  r_q    [dlc_pkg::NS];
    logic [2:0][29:0]          r_em   [dlc_pkg::NS];
    dlc_pkg::t_side            r_side [dlc_pkg::NS];

    for (genvar j = 0; j < dlc_pkg::NS; j++) begin : g_stg
        localparam int IB = dlc_pkg::NS - 1 - j;

        logic [63:0]              w_rem;
        logic [dlc_pkg::DE_W-1:0] w_q;
        logic [2:0][29:0]         w_em;
        dlc_pkg::t_side           w_side;
        logic [63:0]              w_trial;

        if (j == 0) begin : g_first
            assign w_rem  = 64'(i_sq);
            assign w_q    = '0;
            assign w_em   = i_em;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_q    = r_q[j-1];
            assign w_em   = r_em[j-1];
            assign w_side = r_side[j-1];
        end

        // (q + 2^i)^2 - q^2 = q * 2^(i+1) + 2^(2i)
        assign w_trial = (64'(w_q) << (IB + 1)) | (64'd1 << (2 * IB));

        // keep the bit when the trial fits the remainder
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                if (w_rem >= w_trial) begin
                    r_rem[j] <= w_rem - w_trial;
                    r_q[j]   <= w_q | (dlc_pkg::DE_W'(1) << IB);
                end else begin
                    r_rem[j] <= w_rem;
                    r_q[j]   <= w_q;
                end
                r_em[j]   <= w_em;
                r_side[j] <= w_side;
            end
        end
    end

    assign o_de   = r_q[dlc_pkg::NS-1];
    assign o_em   = r_em[dlc_pkg::NS-1];
    assign o_side = r_side[dlc_pkg::NS-1];

endmodule

@@ hw/rtl/dlc_div.sv @@
// ----------------------------------------------------------------------------
// dlc_div
// Pipelined restoring divider, one quotient bit per stage, four lanes that
// share the divisor: three unit-vector quotients and the reciprocal.
// ----------------------------------------------------------------------------
module dlc_div (
    input  logic                                      i_clk,
    input  logic [dlc_pkg::ND-1:0]                    i_en,
    input  logic [dlc_pkg::DE_W-1:0]                  i_de,
    input  logic [2:0][29:0]                          i_em,
    input  dlc_pkg::t_side                            i_side,
    output logic [dlc_pkg::NLANE-1:0][dlc_pkg::DV_W-1:0] o_q,
    output dlc_pkg::t_side                            o_side
);

    localparam int RW = dlc_pkg::DE_W;
    localparam int QW = dlc_pkg::DV_W;

    logic [dlc_pkg::NLANE-1:0][RW-1:0] r_rem  [dlc_pkg::ND];
    logic [dlc_pkg::NLANE-1:0][QW-1:0] r_nq   [dlc_pkg::ND];
    logic [RW-1:0]                     r_de   [dlc_pkg::ND];
    dlc_pkg::t_side                    r_side [dlc_pkg::ND];

    for (genvar j = 0; j < dlc_pkg::ND; j++) begin : g_stg
        logic [dlc_pkg::NLANE-1:0][RW-1:0] w_rem;
        logic [dlc_pkg::NLANE-1:0][QW-1:0] w_nq;
        logic [RW-1:0]                     w_de;
        dlc_pkg::t_side                    w_side;
        logic [QW-1:0]                     w_t  [dlc_pkg::NLANE];
        logic [QW-1:0]                     w_df [dlc_pkg::NLANE];
        logic [dlc_pkg::NLANE-1:0]         w_ge;

        if (j == 0) begin : g_first
            // numerator {em, 30 zeros} for the unit-vector lanes
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign w_rem[l] = RW'(i_em[l][29:2]);
                assign w_nq[l]  = {i_em[l][1:0], 30'd0};
            end
            // numerator 2^61 - 1 for the reciprocal lane
            assign w_rem[dlc_pkg::RCP_LANE] = RW'({29{1'b1}});
            assign w_nq[dlc_pkg::RCP_LANE]  = '1;
            assign w_de   = i_de;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_nq   = r_nq[j-1];
            assign w_de   = r_de[j-1];
            assign w_side = r_side[j-1];
        end

        // bring down the next numerator bit and try the subtract
        always_comb begin
            for (int l = 0; l < dlc_pkg::NLANE; l++) begin
                w_t[l]  = {w_rem[l], w_nq[l][QW-1]};
                w_df[l] = w_t[l] - QW'(w_de);
                w_ge[l] = (w_t[l] >= QW'(w_de));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                for (int l = 0; l < dlc_pkg::NLANE; l++) begin
                    r_rem[j][l] <= w_ge[l] ? w_df[l][RW-1:0] : w_t[l][RW-1:0];
                    r_nq[j][l]  <= {w_nq[l][QW-2:0], w_ge[l]};
                end
                r_de[j]   <= w_de;
                r_side[j] <= w_side;
            end
        end
    end

    assign o_q    = r_nq[dlc_pkg::ND-1];
    assign o_side = r_side[dlc_pkg::ND-1];

endmodule

@@ hw/rtl/dlc_back.sv @@
// ----------------------------------------------------------------------------
// dlc_back
// Back stages: projection n.u, gradient direction, cross product with A,
// scaling by 1/|d|^3 and saturation into the 48-bit result.
// ----------------------------------------------------------------------------
module dlc_back (
    input  logic                                         i_clk,
    input  logic [dlc_pkg::NB-1:0]                       i_en,
    input  logic [dlc_pkg::NLANE-1:0][dlc_pkg::DV_W-1:0] i_q,
    input  dlc_pkg::t_side                               i_side,
    output logic signed [47:0]                           o_curl_x,
    output logic signed [47:0]                           o_curl_y,
    output logic signed [47:0]                           o_curl_z,
    output dlc_pkg::t_status                             o_status
);

    localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

    dlc_pkg::t_side     r_side [11];

    logic signed [31:0] r_u0 [3];
    logic signed [31:0] r_u1 [3];
    logic signed [63:0] r_p  [3];
    logic [63:0]        r_rr;
    logic [31:0]        r_r1_0, r_r1_1;
    logic signed [34:0] r_m;
    logic [31:0]        r_r2;
    logic signed [66:0] r_mu [3];
    logic [63:0]        r_r21;
    logic signed [35:0] r_t  [3];
    logic [31:0]        r_r3_3, r_r3_4, r_r3_5, r_r3_6, r_r3_7, r_r3_8;
    logic signed [33:0] r_vv [3];
    logic signed [65:0] r_pa [6];
    logic [63:0]        r_cm6 [3];
    logic [63:0]        r_cm7 [3];
    logic [2:0]         r_cn6, r_cn7, r_cn8, r_cn9, r_cn10;
    logic [5:0]         r_sb [3];
    logic signed [8:0]  r_s7 [3];
    logic signed [8:0]  r_s8 [3];
    logic signed [8:0]  r_s9 [3];
    logic [31:0]        r_mb [3];
    logic [63:0]        r_prod [3];
    logic [63:0]        r_res [3];
    logic [2:0]         r_ovr;
    logic signed [47:0] r_curl [3];
    dlc_pkg::t_status   r_status;

    logic signed [31:0] w_u   [3];
    logic signed [65:0] w_sum;
    logic [65:0]        w_smag;
    logic [35:0]        w_msh;
    logic [66:0]        w_mum [3];
    logic [36:0]        w_tsh [3];
    logic signed [39:0] w_w   [3];
    logic [39:0]        w_wm  [3];
    logic [37:0]        w_wsh [3];
    logic signed [66:0] w_c   [3];
    logic [6:0]         w_lc  [3];
    logic [5:0]         w_sb  [3];
    int                 w_s   [3];
    logic [63:0]        w_res [3];
    logic [2:0]         w_ovr;
    logic [63:0]        w_lim [3];
    logic [63:0]        w_fin [3];
    logic [2:0]         w_sat;

    // Signed unit vector from the quotient lanes
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (i_side.neg[l]) begin
                w_u[l] = -$signed({1'b0, i_q[l][30:0]});
            end else begin
                w_u[l] = $signed({1'b0, i_q[l][30:0]});
            end
        end
    end

    // m = n.u scaled back by 2^30, truncated toward zero
    always_comb begin
        w_sum  = 66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]);
        w_smag = w_sum[65] ? 66'(-w_sum) : 66'(w_sum);
        w_msh  = 36'(w_smag >> 30);
    end

    // t = m u / 2^30 and v = (n - 3 t) / 4, truncated toward zero
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mum[l] = r_mu[l][66] ? 67'(-r_mu[l]) : 67'(r_mu[l]);
            w_tsh[l] = 37'(w_mum[l] >> 30);
            w_w[l]   = 40'($signed(r_side[3].nv[l])) - 40'(r_t[l]) * 40'sd3;
            w_wm[l]  = w_w[l][39] ? 40'(-w_w[l]) : 40'(w_w[l]);
            w_wsh[l] = 38'(w_wm[l] >> 2);
        end
    end

    // Cross product terms, magnitude and exponent of each component
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_c[l]  = 67'(r_pa[2*l]) - 67'(r_pa[2*l+1]);
            w_lc[l] = dlc_pkg::bitlen64(r_cm6[l]);
            w_sb[l] = (w_lc[l] > 7'd32) ? 6'(w_lc[l] - 7'd32) : 6'd0;
            w_s[l]  = int'(w_sb[l]) + dlc_pkg::FRAC_BITS - 93 - 3 * int'(r_side[6].k);
        end
    end

    // Final scale shift and overflow detect
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!r_s9[l][8]) begin
                w_ovr[l] = ((r_prod[l] >> (7'd48 - 7'(r_s9[l]))) != '0);
                w_res[l] = r_prod[l] << 7'(r_s9[l]);
            end else begin
                w_ovr[l] = 1'b0;
                if (7'(-r_s9[l]) >= 7'd64) begin
                    w_res[l] = '0;
                end else begin
                    w_res[l] = r_prod[l] >> 7'(-r_s9[l]);
                end
            end
        end
    end

    // Clamp to the signed 48-bit range
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_lim[l] = r_cn10[l] ? NEG_LIM : POS_LIM;
            w_sat[l] = r_ovr[l] || (r_res[l] > w_lim[l]);
            w_fin[l] = w_sat[l] ? w_lim[l] : r_res[l];
        end
    end

    always_ff @(posedge i_clk) begin
        // unit vector, n_i u_i, r1 squared
        if (i_en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_u0[l] <= w_u[l];
                r_p[l]  <= 64'($signed(i_side.nv[l])) * 64'(w_u[l]);
            end
            r_rr      <= 64'(i_q[dlc_pkg::RCP_LANE]) * 64'(i_q[dlc_pkg::RCP_LANE]);
            r_r1_0    <= i_q[dlc_pkg::RCP_LANE];
            r_side[0] <= i_side;
        end
        // m and r2
        if (i_en[1]) begin
            r_m       <= w_sum[65] ? -$signed(35'(w_msh)) : $signed(35'(w_msh));
            r_r2      <= r_rr[63:32];
            r_u1      <= r_u0;
            r_r1_1    <= r_r1_0;
            r_side[1] <= r_side[0];
        end
        // m u_i and r2 r1
        if (i_en[2]) begin
            for (int l = 0; l < 3; l++) begin
                r_mu[l] <= 67'(r_m) * 67'(r_u1[l]);
            end
            r_r21     <= 64'(r_r2) * 64'(r_r1_1);
            r_side[2] <= r_side[1];
        end
        // t and r3
        if (i_en[3]) begin
            for (int l = 0; l < 3; l++) begin
                r_t[l] <= r_mu[l][66] ? -$signed(36'(w_tsh[l])) : $signed(36'(w_tsh[l]));
            end
            r_r3_3    <= r_r21[63:32];
            r_side[3] <= r_side[2];
        end
        // gradient direction v
        if (i_en[4]) begin
            for (int l = 0; l < 3; l++) begin
                r_vv[l] <= w_w[l][39] ? -$signed(34'(w_wsh[l])) : $signed(34'(w_wsh[l]));
            end
            r_r3_4    <= r_r3_3;
            r_side[4] <= r_side[3];
        end
        // cross product partial products
        if (i_en[5]) begin
            r_pa[0]   <= 66'(r_vv[1]) * 66'($signed(r_side[4].av[2]));
            r_pa[1]   <= 66'(r_vv[2]) * 66'($signed(r_side[4].av[1]));
            r_pa[2]   <= 66'(r_vv[2]) * 66'($signed(r_side[4].av[0]));
            r_pa[3]   <= 66'(r_vv[0]) * 66'($signed(r_side[4].av[2]));
            r_pa[4]   <= 66'(r_vv[0]) * 66'($signed(r_side[4].av[1]));
            r_pa[5]   <= 66'(r_vv[1]) * 66'($signed(r_side[4].av[0]));
            r_r3_5    <= r_r3_4;
            r_side[5] <= r_side[4];
        end
        // cross product, sign and magnitude
        if (i_en[6]) begin
            for (int l = 0; l < 3; l++) begin
                r_cn6[l] <= w_c[l][66];
                r_cm6[l] <= w_c[l][66] ? 64'(-w_c[l]) : 64'(w_c[l]);
            end
            r_r3_6    <= r_r3_5;
            r_side[6] <= r_side[5];
        end
        // mantissa shift and output exponent
        if (i_en[7]) begin
            for (int l = 0; l < 3; l++) begin
                r_sb[l] <= w_sb[l];
                r_s7[l] <= 9'(w_s[l]);
            end
            r_cm7     <= r_cm6;
            r_cn7     <= r_cn6;
            r_r3_7    <= r_r3_6;
            r_side[7] <= r_side[6];
        end
        // 32-bit mantissa
        if (i_en[8]) begin
            for (int l = 0; l < 3; l++) begin
                r_mb[l] <= 32'(r_cm7[l] >> r_sb[l]);
            end
            r_s8      <= r_s7;
            r_cn8     <= r_cn7;
            r_r3_8    <= r_r3_7;
            r_side[8] <= r_side[7];
        end
        // scale by 1/|d|^3
        if (i_en[9]) begin
            for (int l = 0; l < 3; l++) begin
                r_prod[l] <= 64'(r_mb[l]) * 64'(r_r3_8);
            end
            r_s9      <= r_s8;
            r_cn9     <= r_cn8;
            r_side[9] <= r_side[8];
        end
        // shift into place
        if (i_en[10]) begin
            r_res      <= w_res;
            r_ovr      <= w_ovr;
            r_cn10     <= r_cn9;
            r_side[10] <= r_side[9];
        end
        // clamp, sign and status
        if (i_en[11]) begin
            for (int l = 0; l < 3; l++) begin
                if (r_side[10].zero) begin
                    r_curl[l] <= '0;
                end else if (r_cn10[l]) begin
                    r_curl[l] <= -$signed(w_fin[l][47:0]);
                end else begin
                    r_curl[l] <= $signed(w_fin[l][47:0]);
                end
            end
            if (r_side[10].zero) begin
                r_status <= dlc_pkg::ST_COIN;
            end else if (|w_sat) begin
                r_status <= dlc_pkg::ST_SAT;
            end else begin
                r_status <= dlc_pkg::ST_OK;
            end
        end
    end

    assign o_curl_x = r_curl[0];
    assign o_curl_y = r_curl[1];
    assign o_curl_z = r_curl[2];
    assign o_status = r_status;

endmodule

@@ hw/rtl/double_layer_curl_near_field.sv @@
// ----------------------------------------------------------------------------
// double_layer_curl_near_field
// Near-field double-layer curl kernel: (n/|d|^3 - 3(n.d)d/|d|^5) x A.
// ----------------------------------------------------------------------------
// One word enters per clock unless the pipeline stalls, and each result
// passes 6 front, 31 square-root, 32 divider and 12 back stages; the
// latency is set by the bit-per-stage square root and divider.
// Every stage holds only while it is full and the stage after it holds, so
// empty slots close up and the input keeps taking words while a finished
// result waits at the output. Coincident points give zero and status 2;
// an out-of-range component saturates and gives status 1.
// ----------------------------------------------------------------------------
module double_layer_curl_near_field (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlc_in_if.sink    i_data,
    dlc_out_if.source o_data
);

    logic [dlc_pkg::NSTG-1:0] r_v;
    logic [dlc_pkg::NSTG-1:0] w_en;

    logic [2:0][31:0] w_eval, w_src, w_mom, w_nrm;

    logic [61:0]                                   w_sq;
    logic [2:0][29:0]                              w_em_f, w_em_s;
    dlc_pkg::t_side                                w_side_f, w_side_s, w_side_d;
    logic [dlc_pkg::DE_W-1:0]                      w_de;
    logic [dlc_pkg::NLANE-1:0][dlc_pkg::DV_W-1:0]  w_q;
    dlc_pkg::t_status                              w_status;

    // A stage loads when the output drains or some stage at or after it is empty
    for (genvar s = 0; s < dlc_pkg::NSTG; s++) begin : g_en
        assign w_en[s] = o_data.ready | ~(&r_v[dlc_pkg::NSTG-1:s]);
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_data.valid;
            end
            for (int s = 1; s < dlc_pkg::NSTG; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign i_data.ready = w_en[0];
    assign o_data.valid = r_v[dlc_pkg::NSTG-1];

    assign w_eval = {i_data.eval_z, i_data.eval_y, i_data.eval_x};
    assign w_src  = {i_data.src_z, i_data.src_y, i_data.src_x};
    assign w_mom  = {i_data.moment_z, i_data.moment_y, i_data.moment_x};
    assign w_nrm  = {i_data.normal_z, i_data.normal_y, i_data.normal_x};

    dlc_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[dlc_pkg::SQ_LO-1:0]),
        .i_eval (w_eval),
        .i_src  (w_src),
        .i_mom  (w_mom),
        .i_nrm  (w_nrm),
        .o_sq   (w_sq),
        .o_em   (w_em_f),
        .o_side (w_side_f)
    );

    dlc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[dlc_pkg::DV_LO-1:dlc_pkg::SQ_LO]),
        .i_sq   (w_sq),
        .i_em   (w_em_f),
        .i_side (w_side_f),
        .o_de   (w_de),
        .o_em   (w_em_s),
        .o_side (w_side_s)
    );

    dlc_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en[dlc_pkg::BK_LO-1:dlc_pkg::DV_LO]),
        .i_de   (w_de),
        .i_em   (w_em_s),
        .i_side (w_side_s),
        .o_q    (w_q),
        .o_side (w_side_d)
    );

    dlc_back u_back (
        .i_clk    (i_clk),
        .i_en     (w_en[dlc_pkg::NSTG-1:dlc_pkg::BK_LO]),
        .i_q      (w_q),
        .i_side   (w_side_d),
        .o_curl_x (o_data.curl_x),
        .o_curl_y (o_data.curl_y),
        .o_curl_z (o_data.curl_z),
        .o_status (w_status)
    );

    assign o_data.status = w_status;

endmodule
